// ===== rtl/rgp_pkg.sv =====
`timescale 1ns / 1ps
package rgp_pkg;

  localparam int unsigned CoordBitsDefault = 12;
  localparam int unsigned HeightBits       = 16;
  localparam int unsigned CfgIdxBits       = 3;
  localparam int unsigned CfgDataBits      = 16;

  localparam logic [CfgIdxBits-1:0] CfgCenterX  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgCenterY  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgRadius   = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgMinValue = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgMaxValue = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgFill     = 3'd5;

  typedef struct packed {
    logic [11:0]        pixel_x;
    logic [11:0]        pixel_y;
    logic signed [15:0] old_height;
  } pix_t;

  typedef struct packed {
    logic signed [15:0] new_height;
    logic               was_written;
  } res_t;

endpackage

// ===== rtl/rgp_sqrt.sv =====
`timescale 1ns / 1ps
module rgp_sqrt #(
  parameter int unsigned RW    = 13,
  parameter int unsigned TAG_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic              vld_o,
  output logic [RW-1:0]     root_o,
  output logic [TAG_W-1:0]  tag_o
);

  logic              vld_q  [RW];
  logic [2*RW-1:0]   rad_q  [RW];
  logic [RW+1:0]     rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [TAG_W-1:0]  tag_q  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic             pv;
    logic [2*RW-1:0]  prad;
    logic [RW+1:0]    prem;
    logic [RW-1:0]    proot;
    logic [TAG_W-1:0] ptag;
    logic [RW+1:0]    rem_sh;
    logic [RW+1:0]    trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign pv    = vld_i;
      assign prad  = rad_i;
      assign prem  = '0;
      assign proot = '0;
      assign ptag  = tag_i;
    end else begin : g_next
      assign pv    = vld_q[i-1];
      assign prad  = rad_q[i-1];
      assign prem  = rem_q[i-1];
      assign proot = root_q[i-1];
      assign ptag  = tag_q[i-1];
    end

    // bring down the next two radicand bits
    assign rem_sh = {prem[RW-1:0], prad[2*RW-1 -: 2]};
    assign trial  = {proot, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[i]  <= prad << 2;
      rem_q[i]  <= ge ? rem_sh - trial : rem_sh;
      root_q[i] <= {proot[RW-2:0], ge};
      tag_q[i]  <= ptag;
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign tag_o  = tag_q[RW-1];

endmodule

// ===== rtl/rgp_div.sv =====
`timescale 1ns / 1ps
module rgp_div #(
  parameter int unsigned W     = 16,
  parameter int unsigned TAG_W = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [2*W-1:0]    num_i,
  input  logic [W-1:0]      den_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic              vld_o,
  output logic [W-1:0]      quo_o,
  output logic [TAG_W-1:0]  tag_o
);

  // The upper half of the dividend must be below the divisor.
  logic              vld_q [W];
  logic [W-1:0]      rem_q [W];
  logic [W-1:0]      low_q [W];
  logic [W-1:0]      quo_q [W];
  logic [W-1:0]      den_q [W];
  logic [TAG_W-1:0]  tag_q [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic             pv;
    logic [W-1:0]     prem;
    logic [W-1:0]     plow;
    logic [W-1:0]     pquo;
    logic [W-1:0]     pden;
    logic [TAG_W-1:0] ptag;
    logic [W:0]       t;
    logic             ge;
    logic [W:0]       diff;

    if (i == 0) begin : g_first
      assign pv   = vld_i;
      assign prem = num_i[2*W-1:W];
      assign plow = num_i[W-1:0];
      assign pquo = '0;
      assign pden = den_i;
      assign ptag = tag_i;
    end else begin : g_next
      assign pv   = vld_q[i-1];
      assign prem = rem_q[i-1];
      assign plow = low_q[i-1];
      assign pquo = quo_q[i-1];
      assign pden = den_q[i-1];
      assign ptag = tag_q[i-1];
    end

    assign t    = {prem, plow[W-1]};
    assign ge   = t >= {1'b0, pden};
    assign diff = t - {1'b0, pden};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= ge ? diff[W-1:0] : t[W-1:0];
      low_q[i] <= plow << 1;
      quo_q[i] <= {pquo[W-2:0], ge};
      den_q[i] <= pden;
      tag_q[i] <= ptag;
    end
  end

  assign vld_o = vld_q[W-1];
  assign quo_o = quo_q[W-1];
  assign tag_o = tag_q[W-1];

endmodule

// ===== rtl/radial_gradient_pixel.sv =====
`timescale 1ns / 1ps
// Radial gradient painter, one pixel beat per clock.
// Command channel: drive pix_i and pulse start_i; a beat is taken at every
// rising edge with start_i high and busy_o low. busy_o is always low, so a
// new pixel may enter in every cycle.
// Result channel: res_valid_o is high for exactly one cycle with res_o;
// the receiver cannot stall and the pipeline never holds.
// Pipeline: one stage for the distance terms, one for the squares, one for the
// sum, COORD_BITS + 1 square-root stages (one root bit each), one for span
// times distance, sixteen divider stages (one quotient bit each) and the
// output register.
// Throughput is one pixel per cycle.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i; write
// only while no pixel is in flight. Unknown indexes are ignored.
// Reset clears all pipeline valid bits and loads the register defaults
// (radius 1, everything else 0).
module radial_gradient_pixel #(
  parameter int unsigned COORD_BITS = rgp_pkg::CoordBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  rgp_pkg::pix_t                     pix_i,
  output logic                              res_valid_o,
  output rgp_pkg::res_t                     res_o,
  input  logic                              cfg_we_i,
  input  logic [rgp_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [rgp_pkg::CfgDataBits-1:0]   cfg_data_i
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned RW = COORD_BITS + 1;
  localparam int unsigned HB = rgp_pkg::HeightBits;

  // configuration
  logic [11:0] cx_q, cy_q;
  logic [15:0] radius_q;
  logic [15:0] min_q, max_q;
  logic        fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      radius_q <= 16'd1;
      min_q    <= '0;
      max_q    <= '0;
      fill_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rgp_pkg::CfgCenterX:  cx_q     <= cfg_data_i[11:0];
        rgp_pkg::CfgCenterY:  cy_q     <= cfg_data_i[11:0];
        rgp_pkg::CfgRadius:   radius_q <= cfg_data_i;
        rgp_pkg::CfgMinValue: min_q    <= cfg_data_i;
        rgp_pkg::CfgMaxValue: max_q    <= cfg_data_i;
        rgp_pkg::CfgFill:     fill_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [HB-1:0] span;
  assign span = max_q - min_q;

  assign busy_o = 1'b0;
  logic acc;
  assign acc = start_i && !busy_o;

  // stage 1: absolute differences
  logic [CB-1:0] px, py, cx, cy;
  assign px = CB'(pix_i.pixel_x);
  assign py = CB'(pix_i.pixel_y);
  assign cx = CB'(cx_q);
  assign cy = CB'(cy_q);

  logic          v1_q, v2_q, v3_q;
  logic [CB-1:0] dx_q, dy_q;
  logic [HB-1:0] old1_q, old2_q, old3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  logic [2*CB-1:0] sqx_q, sqy_q;
  logic [2*RW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    dx_q   <= (px > cx) ? px - cx : cx - px;
    dy_q   <= (py > cy) ? py - cy : cy - py;
    old1_q <= pix_i.old_height;
    // stage 2: squares
    sqx_q  <= dx_q * dx_q;
    sqy_q  <= dy_q * dy_q;
    old2_q <= old1_q;
    // stage 3: sum of squares
    sum_q  <= (2*RW)'(sqx_q) + (2*RW)'(sqy_q);
    old3_q <= old2_q;
  end

  logic          sq_vld;
  logic [RW-1:0] sq_root;
  logic [HB-1:0] sq_old;

  rgp_sqrt #(
    .RW   (RW),
    .TAG_W(HB)
  ) u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (v3_q),
    .rad_i (sum_q),
    .tag_i (old3_q),
    .vld_o (sq_vld),
    .root_o(sq_root),
    .tag_o (sq_old)
  );

  // product stage: |span| * distance, sign and disc test held beside it
  logic [HB-1:0] dist16;
  logic [HB-1:0] span_mag;
  assign dist16   = HB'(sq_root);
  assign span_mag = span[HB-1] ? HB'(-span) : span;

  logic            vp_q;
  logic [2*HB-1:0] prod_q;
  logic            inside_q, neg_q;
  logic [HB-1:0]   oldp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= span_mag * dist16;
    inside_q <= dist16 < radius_q;
    neg_q    <= span[HB-1];
    oldp_q   <= sq_old;
  end

  logic          dv_vld;
  logic [HB-1:0] quo;
  logic [HB+1:0] dv_tag;

  // outside the disc the dividend may exceed the limit; that quotient is unused
  rgp_div #(
    .W    (HB),
    .TAG_W(HB + 2)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (vp_q),
    .num_i (prod_q),
    .den_i (radius_q),
    .tag_i ({inside_q, neg_q, oldp_q}),
    .vld_o (dv_vld),
    .quo_o (quo),
    .tag_o (dv_tag)
  );

  logic          dv_inside, dv_neg;
  logic [HB-1:0] dv_old;
  logic [HB-1:0] q_signed;
  assign dv_inside = dv_tag[HB+1];
  assign dv_neg    = dv_tag[HB];
  assign dv_old    = dv_tag[HB-1:0];
  assign q_signed  = dv_neg ? HB'(-quo) : quo;

  logic          res_vld_q;
  rgp_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_inside) begin
      res_q.new_height  <= min_q + q_signed;
      res_q.was_written <= 1'b1;
    end else if (fill_q) begin
      res_q.new_height  <= min_q + span;
      res_q.was_written <= 1'b1;
    end else begin
      res_q.new_height  <= dv_old;
      res_q.was_written <= 1'b0;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_strobe_follows_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(dv_vld))
    else $error("result strobe without a divider beat");
  a_inside_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld && dv_inside) |=> (res_valid_o && res_o.was_written))
    else $error("pixel inside the disc not painted");
  a_keep_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld && !dv_inside && !fill_q) |=>
      (res_valid_o && !res_o.was_written && res_o.new_height == $past(dv_old)))
    else $error("kept pixel altered");
`endif

endmodule
